// ----- hw/rtl/load_cell_weight_conditioner_core_macros.svh -----
// Assertion macros for the checker file of the load cell conditioner.
// No dependencies; take it in with an include of the bare file name.
`ifndef LOAD_CELL_WEIGHT_CONDITIONER_CORE_MACROS_SVH
`define LOAD_CELL_WEIGHT_CONDITIONER_CORE_MACROS_SVH

// Checked at every rising edge, switched off while reset is asserted.
`define LCWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define LCWC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/lcwc_pkg.sv -----
// Package of the load cell weight conditioner: field widths, command and status codes,
// and the limits that the sequencer compares against. No dependencies.
`timescale 1ns / 1ps

package lcwc_pkg;

    localparam int RAW_W    = 24;
    localparam int KNOWN_W  = 24;
    localparam int FACTOR_W = 32;
    localparam int WEIGHT_W = 33;
    localparam int STATUS_W = 4;
    localparam int CMD_W    = 2;
    localparam int LEN_W    = 8;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 96;

    localparam int DEFAULT_WINDOW_DEPTH = 10;

    // Shared divider widths: signed dividend, signed divisor, magnitude widths.
    localparam int DVD_W     = 42;
    localparam int DVS_W     = 33;
    localparam int MAG_W     = 41;
    localparam int DVS_MAG_W = 32;
    localparam int DIV_CNT_W = 6;

    localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TARE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CAL     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd3;

    localparam logic [CMD_W-1:0] KIND_NONE = 2'd0;

    localparam logic [STATUS_W-1:0] ST_WEIGHT     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_ACCUM      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_TARED      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_CALIBRATED = 4'd4;
    localparam logic [STATUS_W-1:0] ST_NO_VALID   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_DELTA_SMALL = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_WEIGHT = 4'd7;
    localparam logic [STATUS_W-1:0] ST_LOADED     = 4'd8;

    localparam logic [LEN_W-1:0] MIN_BATCH = 8'd20;
    localparam logic [LEN_W-1:0] DEFAULT_BATCH_LENGTH = 8'd20;

    localparam logic signed [RAW_W-1:0] RAIL_HI      = 24'sh7FFFFF;
    localparam logic signed [RAW_W-1:0] RAIL_LO      = 24'sh800000;
    localparam logic signed [RAW_W-1:0] REJECT_LIMIT = 24'sd8000000;
    localparam logic signed [RAW_W:0]   MIN_DELTA    = 25'sd50;
    localparam logic signed [FACTOR_W-1:0] ONE_Q8    = 32'sd256;
    localparam int UNCAL_DIVISOR = 10000;

endpackage

// ----- hw/rtl/lcwc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lcwc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/lcwc_div.sv -----
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on lcwc_pkg for the operand widths.
`timescale 1ns / 1ps

module lcwc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [lcwc_pkg::DVD_W-1:0]  dividend,
    input  logic signed [lcwc_pkg::DVS_W-1:0]  divisor,
    output logic                               done,
    output logic signed [lcwc_pkg::DVD_W-1:0]  quotient
);

    localparam int DVD_W = lcwc_pkg::DVD_W;
    localparam int DVS_W = lcwc_pkg::DVS_W;
    localparam int MAG_W = lcwc_pkg::MAG_W;
    localparam int DM_W  = lcwc_pkg::DVS_MAG_W;
    localparam int CNT_W = lcwc_pkg::DIV_CNT_W;

    logic             busy_reg, busy_next;
    logic             fix_reg, fix_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DM_W-1:0]  dvs_reg, dvs_next;
    logic [DM_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0] acc_reg, acc_next;
    logic signed [DVD_W-1:0] quot_reg, quot_next;

    logic [DVD_W-1:0] dvd_abs;
    logic [DVS_W-1:0] dvs_abs;
    logic [DM_W:0]    trial;
    logic [DM_W:0]    diff;
    logic             ge;

    always_comb begin
        dvd_abs = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
        dvs_abs = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
        trial   = {rem_reg, acc_reg[MAG_W-1]};
        diff    = trial - {1'b0, dvs_reg};
        ge      = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        quot_next = quot_reg;

        if (start) begin
            busy_next = 1'b1;
            neg_next  = dividend[DVD_W-1] ^ divisor[DVS_W-1];
            cnt_next  = '0;
            dvs_next  = dvs_abs[DM_W-1:0];
            rem_next  = '0;
            acc_next  = dvd_abs[MAG_W-1:0];
        end else if (busy_reg) begin
            rem_next = ge ? diff[DM_W-1:0] : trial[DM_W-1:0];
            acc_next = {acc_reg[MAG_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end else if (fix_reg) begin
            quot_next = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- hw/rtl/load_cell_weight_conditioner_core.sv -----
// Top level of the load cell weight conditioner: sequencer, filter ring, batch logic.
// Depends on lcwc_pkg, lcwc_ram and lcwc_div.
`timescale 1ns / 1ps

// Channel   Direction  tuser                tdata
// s_        in         [1:0] command        raw_sample, known_weight, offset_in, factor_in
// m_        out        [3:0] status         weight, zero_offset_out, cal_factor_out
// cfg_      in         -                    [7:0] batch_length (write only)
//
// One word is taken at a time; s_tready is low until its result is in the output register.
// A division on the shared one-bit-per-cycle divider holds the sequencer until it is done. A
// measure word takes a reciprocal multiply for the mean of a full ring and one division for the
// weight; a closing calibrate takes two divisions (one on a small delta), a closing tare one,
// and rejects, loads, open batches and batches with no valid sample none. Reset (aresetn low,
// synchronous) zeroes the ring through per-entry valid bits; a stalled m_ side holds the word.

module load_cell_weight_conditioner_core #(
    parameter int WINDOW_DEPTH = lcwc_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input words.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcwc_pkg::CMD_W-1:0]          s_tuser,  // [1:0] command
    // From bit 0: raw_sample, known_weight, offset_in, factor_in.
    input  logic [lcwc_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result words.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcwc_pkg::STATUS_W-1:0]       m_tuser,  // [3:0] status
    // From bit 0: weight, zero_offset_out, cal_factor_out, zero fill.
    output logic [lcwc_pkg::M_TDATA_W-1:0]      m_tdata,
    // Batch length register.
    input  logic                                cfg_wr_en,
    input  logic [lcwc_pkg::LEN_W-1:0]          cfg_wr_data
);

    localparam int RAW_W = lcwc_pkg::RAW_W;
    localparam int FAC_W = lcwc_pkg::FACTOR_W;
    localparam int WGT_W = lcwc_pkg::WEIGHT_W;
    localparam int LEN_W = lcwc_pkg::LEN_W;
    localparam int DVD_W = lcwc_pkg::DVD_W;
    localparam int DVS_W = lcwc_pkg::DVS_W;
    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W = RAW_W + $clog2(WINDOW_DEPTH + 1);
    localparam int BSUM_W = 32;

    localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

    // The ring mean is the sum magnitude times a rounded-up reciprocal, shifted down.
    // With the shift this large the result is exact for every sum the ring can hold.
    localparam int MEAN_SH = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int MUL_W   = SUM_W + 1;
    localparam longint MEAN_MUL_L = ((longint'(1) <<< MEAN_SH) + longint'(WINDOW_DEPTH)
                                     - longint'(1)) / longint'(WINDOW_DEPTH);
    localparam logic [MUL_W-1:0] MEAN_MUL = MUL_W'(MEAN_MUL_L);

    // Sequencer states.
    localparam logic [3:0] S_IDLE         = 4'd0;
    localparam logic [3:0] S_READ         = 4'd1;
    localparam logic [3:0] S_MEAN         = 4'd2;
    localparam logic [3:0] S_WEIGHT_START = 4'd3;
    localparam logic [3:0] S_WEIGHT_WAIT  = 4'd4;
    localparam logic [3:0] S_AVG_WAIT     = 4'd5;
    localparam logic [3:0] S_CAL_WAIT     = 4'd6;
    localparam logic [3:0] S_PREFILL      = 4'd7;
    localparam logic [3:0] S_DONE         = 4'd8;

    logic [3:0] state_reg, state_next;

    logic [LEN_W-1:0] batch_length_reg, batch_length_next;

    // Word being worked on.
    logic [1:0]                 cmd_reg, cmd_next;
    logic signed [RAW_W-1:0]    raw_reg, raw_next;
    logic [RAW_W-1:0]           known_reg, known_next;
    logic [3:0]                 status_reg, status_next;
    logic signed [WGT_W-1:0]    weight_reg, weight_next;
    logic signed [RAW_W-1:0]    avg_reg, avg_next;

    // Filter ring bookkeeping; the entries themselves live in the RAM.
    logic [PTR_W-1:0]           pos_reg, pos_next;
    logic                       filled_reg, filled_next;
    logic [WINDOW_DEPTH-1:0]    valid_reg, valid_next;
    logic signed [RAW_W-1:0]    fill_val_reg, fill_val_next;
    logic signed [SUM_W-1:0]    ring_sum_reg, ring_sum_next;
    logic signed [RAW_W-1:0]    filtered_reg, filtered_next;

    logic signed [RAW_W-1:0]    offset_reg, offset_next;
    logic signed [FAC_W-1:0]    factor_reg, factor_next;

    logic signed [BSUM_W-1:0]   bsum_reg, bsum_next;
    logic [LEN_W-1:0]           bcount_reg, bcount_next;
    logic [LEN_W-1:0]           battempts_reg, battempts_next;
    logic [1:0]                 bkind_reg, bkind_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [3:0]                 m_tuser_reg, m_tuser_next;
    logic [lcwc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Shared divider hookup.
    logic                       div_start;
    logic signed [DVD_W-1:0]    div_dividend;
    logic signed [DVS_W-1:0]    div_divisor;
    logic                       div_done;
    logic signed [DVD_W-1:0]    div_quot;

    logic                       ram_wr_en;
    logic [RAW_W-1:0]           ram_rd_data;

    // Input field views.
    logic [1:0]                 in_cmd;
    logic signed [RAW_W-1:0]    in_raw;
    logic [RAW_W-1:0]           in_known;
    logic signed [RAW_W-1:0]    in_offset;
    logic signed [FAC_W-1:0]    in_factor;

    logic                       accept;
    logic                       rail;
    logic                       reject;
    logic [LEN_W-1:0]           need;
    logic signed [BSUM_W-1:0]   b_sum_base, b_sum_new;
    logic [LEN_W-1:0]           b_cnt_base, b_cnt_new;
    logic [LEN_W-1:0]           b_att_base, b_att_new;
    logic signed [RAW_W-1:0]    old_entry;
    logic signed [SUM_W-1:0]    sum_upd;
    logic [PTR_W-1:0]           pos_inc;
    logic                       filled_upd;
    logic signed [RAW_W:0]      delta;
    logic signed [RAW_W:0]      cal_delta;
    logic signed [SUM_W-1:0]    avg_ext;
    logic                       uncal;
    logic                       q_fits33;
    logic                       q_fits32;
    logic [SUM_W-1:0]           sum_mag;
    logic [SUM_W+MUL_W-1:0]     mean_prod;
    logic [SUM_W-1:0]           mean_mag;
    logic signed [SUM_W-1:0]    mean_val;

    assign in_cmd    = s_tuser;
    assign in_raw    = s_tdata[23:0];
    assign in_known  = s_tdata[47:24];
    assign in_offset = s_tdata[71:48];
    assign in_factor = s_tdata[103:72];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    lcwc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    lcwc_ram #(
        .WIDTH (RAW_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (raw_reg),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        // Combinational helpers used by several states.
        rail   = (in_raw == lcwc_pkg::RAIL_HI) || (in_raw == lcwc_pkg::RAIL_LO);
        reject = rail || (in_raw > lcwc_pkg::REJECT_LIMIT) || (in_raw < -lcwc_pkg::REJECT_LIMIT);
        need   = (batch_length_reg < lcwc_pkg::MIN_BATCH) ? lcwc_pkg::MIN_BATCH
                                                         : batch_length_reg;

        // A batch of another kind is dropped before this sample joins.
        b_sum_base = (bkind_reg == in_cmd) ? bsum_reg : '0;
        b_cnt_base = (bkind_reg == in_cmd) ? bcount_reg : '0;
        b_att_base = (bkind_reg == in_cmd) ? battempts_reg : '0;
        b_sum_new  = rail ? b_sum_base : b_sum_base + BSUM_W'(in_raw);
        b_cnt_new  = rail ? b_cnt_base : b_cnt_base + 1'b1;
        b_att_new  = b_att_base + 1'b1;

        old_entry  = valid_reg[pos_reg] ? $signed(ram_rd_data) : fill_val_reg;
        sum_upd    = ring_sum_reg + SUM_W'(raw_reg) - SUM_W'(old_entry);
        pos_inc    = (pos_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        filled_upd = filled_reg || (pos_inc == '0);

        // Mean of the ring, truncated toward zero.
        sum_mag    = ring_sum_reg[SUM_W-1] ? SUM_W'(-ring_sum_reg) : SUM_W'(ring_sum_reg);
        mean_prod  = (SUM_W+MUL_W)'(sum_mag) * (SUM_W+MUL_W)'(MEAN_MUL);
        mean_mag   = SUM_W'(mean_prod >> MEAN_SH);
        mean_val   = ring_sum_reg[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);

        delta      = (RAW_W+1)'(filtered_reg) - (RAW_W+1)'(offset_reg);
        cal_delta  = (RAW_W+1)'(avg_reg) - (RAW_W+1)'(offset_reg);
        avg_ext    = SUM_W'(avg_reg);
        uncal      = (factor_reg > -lcwc_pkg::ONE_Q8) && (factor_reg < lcwc_pkg::ONE_Q8);

        // The quotient fits when all bits above the target sign bit copy it.
        q_fits33   = (div_quot[DVD_W-1:WGT_W-1] == '0) || (div_quot[DVD_W-1:WGT_W-1] == '1);
        q_fits32   = (div_quot[DVD_W-1:FAC_W-1] == '0) || (div_quot[DVD_W-1:FAC_W-1] == '1);

        state_next        = state_reg;
        batch_length_next = cfg_wr_en ? cfg_wr_data : batch_length_reg;
        cmd_next          = cmd_reg;
        raw_next          = raw_reg;
        known_next        = known_reg;
        status_next       = status_reg;
        weight_next       = weight_reg;
        avg_next          = avg_reg;
        pos_next          = pos_reg;
        filled_next       = filled_reg;
        valid_next        = valid_reg;
        fill_val_next     = fill_val_reg;
        ring_sum_next     = ring_sum_reg;
        filtered_next     = filtered_reg;
        offset_next       = offset_reg;
        factor_next       = factor_reg;
        bsum_next         = bsum_reg;
        bcount_next       = bcount_reg;
        battempts_next    = battempts_reg;
        bkind_next        = bkind_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tuser_next      = m_tuser_reg;
        m_tdata_next      = m_tdata_reg;
        div_start         = 1'b0;
        div_dividend      = '0;
        div_divisor       = '0;
        ram_wr_en         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next    = in_cmd;
                    raw_next    = in_raw;
                    known_next  = in_known;
                    weight_next = '0;
                    state_next  = S_DONE;
                    if (in_cmd != bkind_reg) begin
                        bsum_next      = '0;
                        bcount_next    = '0;
                        battempts_next = '0;
                        bkind_next     = lcwc_pkg::KIND_NONE;
                    end
                    case (in_cmd)
                        lcwc_pkg::CMD_MEASURE: begin
                            if (reject) begin
                                status_next = lcwc_pkg::ST_REJECTED;
                            end else begin
                                // The RAM returns the entry at pos_reg next cycle.
                                state_next = S_READ;
                            end
                        end
                        lcwc_pkg::CMD_LOAD: begin
                            offset_next = in_offset;
                            factor_next = in_factor;
                            status_next = lcwc_pkg::ST_LOADED;
                        end
                        default: begin
                            if (in_cmd == lcwc_pkg::CMD_CAL && in_known == '0) begin
                                bsum_next      = '0;
                                bcount_next    = '0;
                                battempts_next = '0;
                                bkind_next     = lcwc_pkg::KIND_NONE;
                                status_next    = lcwc_pkg::ST_BAD_WEIGHT;
                            end else if (b_att_new < need) begin
                                bsum_next      = b_sum_new;
                                bcount_next    = b_cnt_new;
                                battempts_next = b_att_new;
                                bkind_next     = in_cmd;
                                status_next    = lcwc_pkg::ST_ACCUM;
                            end else begin
                                // The batch closes with this word either way.
                                bsum_next      = '0;
                                bcount_next    = '0;
                                battempts_next = '0;
                                bkind_next     = lcwc_pkg::KIND_NONE;
                                if (b_cnt_new == '0) begin
                                    status_next = lcwc_pkg::ST_NO_VALID;
                                end else begin
                                    div_start    = 1'b1;
                                    div_dividend = DVD_W'(b_sum_new);
                                    div_divisor  = DVS_W'({1'b0, b_cnt_new});
                                    state_next   = S_AVG_WAIT;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                ram_wr_en             = 1'b1;
                valid_next[pos_reg]   = 1'b1;
                ring_sum_next         = sum_upd;
                pos_next              = pos_inc;
                filled_next           = filled_upd;
                if (filled_upd) begin
                    state_next    = S_MEAN;
                end else begin
                    filtered_next = raw_reg;
                    state_next    = S_WEIGHT_START;
                end
            end
            S_MEAN: begin
                filtered_next = mean_val[RAW_W-1:0];
                state_next    = S_WEIGHT_START;
            end
            S_WEIGHT_START: begin
                div_start = 1'b1;
                if (uncal) begin
                    div_dividend = {{(DVD_W-RAW_W-9){delta[RAW_W]}}, delta, 8'b0};
                    div_divisor  = DVS_W'(lcwc_pkg::UNCAL_DIVISOR);
                end else begin
                    div_dividend = {{(DVD_W-RAW_W-17){delta[RAW_W]}}, delta, 16'b0};
                    div_divisor  = DVS_W'(factor_reg);
                end
                state_next = S_WEIGHT_WAIT;
            end
            S_WEIGHT_WAIT: begin
                if (div_done) begin
                    if (q_fits33) begin
                        weight_next = div_quot[WGT_W-1:0];
                    end else begin
                        weight_next = div_quot[DVD_W-1] ? {1'b1, {(WGT_W-1){1'b0}}}
                                                        : {1'b0, {(WGT_W-1){1'b1}}};
                    end
                    status_next = lcwc_pkg::ST_WEIGHT;
                    state_next  = S_DONE;
                end
            end
            S_AVG_WAIT: begin
                if (div_done) begin
                    avg_next = div_quot[RAW_W-1:0];
                    if (cmd_reg == lcwc_pkg::CMD_TARE) begin
                        offset_next = div_quot[RAW_W-1:0];
                        state_next  = S_PREFILL;
                    end else begin
                        state_next  = S_CAL_WAIT;
                    end
                end
            end
            S_CAL_WAIT: begin
                // On entry, starts the factor division from avg_reg or flags a small delta.
                if (!div_done && status_reg != lcwc_pkg::ST_CALIBRATED) begin
                    if (cal_delta > -lcwc_pkg::MIN_DELTA && cal_delta < lcwc_pkg::MIN_DELTA) begin
                        status_next = lcwc_pkg::ST_DELTA_SMALL;
                        state_next  = S_DONE;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = {{(DVD_W-RAW_W-17){cal_delta[RAW_W]}}, cal_delta, 16'b0};
                        div_divisor  = DVS_W'({1'b0, known_reg});
                        status_next  = lcwc_pkg::ST_CALIBRATED;
                    end
                end else if (div_done) begin
                    if (q_fits32) begin
                        factor_next = div_quot[FAC_W-1:0];
                    end else begin
                        factor_next = div_quot[DVD_W-1] ? {1'b1, {(FAC_W-1){1'b0}}}
                                                        : {1'b0, {(FAC_W-1){1'b1}}};
                    end
                    state_next = S_PREFILL;
                end
            end
            S_PREFILL: begin
                // Every entry reads as avg_reg until it is written again.
                fill_val_next = avg_reg;
                valid_next    = '0;
                pos_next      = '0;
                ring_sum_next = avg_ext * DEPTH_S;
                if (cmd_reg == lcwc_pkg::CMD_CAL) begin
                    filled_next   = 1'b1;
                    filtered_next = avg_reg;
                    status_next   = lcwc_pkg::ST_CALIBRATED;
                end else begin
                    filled_next   = 1'b0;
                    status_next   = lcwc_pkg::ST_TARED;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {7'b0, factor_reg, offset_reg, weight_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // The calibrated marker in status_reg only guards the factor division start.
        if (state_reg == S_IDLE && accept) begin
            if (in_cmd == lcwc_pkg::CMD_CAL && status_next == lcwc_pkg::ST_CALIBRATED) begin
                status_next = lcwc_pkg::ST_ACCUM;
            end
        end
        if (state_reg == S_AVG_WAIT) begin
            status_next = lcwc_pkg::ST_ACCUM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            batch_length_reg <= lcwc_pkg::DEFAULT_BATCH_LENGTH;
            pos_reg          <= '0;
            filled_reg       <= 1'b0;
            valid_reg        <= '0;
            fill_val_reg     <= '0;
            ring_sum_reg     <= '0;
            filtered_reg     <= '0;
            offset_reg       <= '0;
            factor_reg       <= '0;
            bsum_reg         <= '0;
            bcount_reg       <= '0;
            battempts_reg    <= '0;
            bkind_reg        <= lcwc_pkg::KIND_NONE;
            status_reg       <= lcwc_pkg::ST_WEIGHT;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            batch_length_reg <= batch_length_next;
            pos_reg          <= pos_next;
            filled_reg       <= filled_next;
            valid_reg        <= valid_next;
            fill_val_reg     <= fill_val_next;
            ring_sum_reg     <= ring_sum_next;
            filtered_reg     <= filtered_next;
            offset_reg       <= offset_next;
            factor_reg       <= factor_next;
            bsum_reg         <= bsum_next;
            bcount_reg       <= bcount_next;
            battempts_reg    <= battempts_next;
            bkind_reg        <= bkind_next;
            status_reg       <= status_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        cmd_reg     <= cmd_next;
        raw_reg     <= raw_next;
        known_reg   <= known_next;
        weight_reg  <= weight_next;
        avg_reg     <= avg_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/lcwc_checker.sv -----
// Port-level checker for the load cell weight conditioner, bound to the top level.
// Depends on lcwc_pkg and load_cell_weight_conditioner_core_macros.svh.
`timescale 1ns / 1ps
`include "load_cell_weight_conditioner_core_macros.svh"

module lcwc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [3:0]  m_tuser,
    input logic [95:0] m_tdata
);

    `LCWC_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `LCWC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `LCWC_ASSERT(a_one_word, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second word taken while busy")
    `LCWC_ASSERT(a_status_range, aclk, aresetn, m_tvalid |-> m_tuser <= lcwc_pkg::ST_LOADED, "status out of range")
    `LCWC_ASSERT(a_weight_zero, aclk, aresetn, m_tvalid && m_tuser != lcwc_pkg::ST_WEIGHT |-> m_tdata[32:0] == 33'd0, "weight set for non-weight status")

endmodule

bind load_cell_weight_conditioner_core lcwc_checker u_lcwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);
